FILE: hw/rtl/dpb_pkg.sv
// shared constants for the depth pixel back-projection block
// register map, reset values and default coordinate width; no dependencies
`default_nettype none

package dpb_pkg;

	localparam int COORD_BITS_DEF = 12;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	// register indexes (byte address is 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_FOCAL_X_RECIP     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y_RECIP     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X          = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y          = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DEPTH_SCALE_RECIP = 3'd4;

	localparam int RECIP_W  = 32;
	localparam int CENTER_W = 16;
	localparam int DSR_W    = 24;
	localparam int DEPTH_W  = 16;
	localparam int COLOR_W  = 8;
	localparam int POINT_W  = 32;

	localparam logic [RECIP_W-1:0]  FOCAL_X_RECIP_RST     = 32'd8181019;
	localparam logic [RECIP_W-1:0]  FOCAL_Y_RECIP_RST     = 32'd8181019;
	localparam logic [CENTER_W-1:0] CENTER_X_RST          = 16'd5112;
	localparam logic [CENTER_W-1:0] CENTER_Y_RST          = 16'd3832;
	localparam logic [DSR_W-1:0]    DEPTH_SCALE_RECIP_RST = 24'd16777;

endpackage

`default_nettype wire

FILE: hw/rtl/depth_pixel_backprojection_top.sv
// Pinhole depth pixel to 3-D point back-projection, four-stage pipeline.
// Takes types and constants from dpb_pkg.
`default_nettype none

// One pixel enters per clock while pixel_stall is low; its point leaves through
// the registers of stages one to four. Stage one forms z = depth_raw *
// depth_scale_recip >> 8 and the signed offsets from the principal point, stage
// two multiplies each offset magnitude by z, stage three splits the multiply by
// the focal reciprocal into two partial products, and stage four adds them,
// truncates toward zero, saturates to signed 32 bits and applies the sign. A
// pixel whose z is zero is dropped at stage one and gives no point. Each stage
// holds only while it has an item and the stage after it holds too, so a
// stalled output still lets the pipeline fill. Configuration registers sit on
// an APB-style port at byte addresses 0, 4, 8, 12 and 16; the user must write
// them only while the block is idle, which the block itself does not enforce.
module depth_pixel_backprojection_top import dpb_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// apb configuration
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [APB_ADDR_W-1:0]   paddr,
	input  wire logic [APB_DATA_W-1:0]   pwdata,
	output logic      [APB_DATA_W-1:0]   prdata,
	output logic                         pready,
	// pixel channel
	input  wire logic                    pixel_valid,
	output logic                         pixel_stall,
	input  wire logic [COORD_BITS-1:0]   column,
	input  wire logic [COORD_BITS-1:0]   row,
	input  wire logic [DEPTH_W-1:0]      depth_raw,
	input  wire logic [COLOR_W-1:0]      red_in,
	input  wire logic [COLOR_W-1:0]      green_in,
	input  wire logic [COLOR_W-1:0]      blue_in,
	// point channel
	output logic                         point_valid,
	input  wire logic                    point_stall,
	output logic signed [POINT_W-1:0]    point_x,
	output logic signed [POINT_W-1:0]    point_y,
	output logic      [POINT_W-1:0]      point_z,
	output logic      [COLOR_W-1:0]      red_out,
	output logic      [COLOR_W-1:0]      green_out,
	output logic      [COLOR_W-1:0]      blue_out
);

	localparam int MAG_W  = (COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W;
	localparam int OFF_W  = MAG_W + 1;
	localparam int PROD_W = DEPTH_W + DSR_W;
	localparam int M_W    = MAG_W + POINT_W;
	localparam int MH_W   = M_W - 32;
	localparam int PHI_W  = MH_W + RECIP_W;
	localparam int SUM_W  = PHI_W + 1;
	localparam int Q_W    = SUM_W - 4;

	localparam logic [Q_W-1:0] POS_LIM = Q_W'(32'h7FFF_FFFF);
	localparam logic [Q_W-1:0] NEG_LIM = Q_W'(32'h8000_0000);

	// configuration registers
	logic [RECIP_W-1:0]  focal_x_recip_q;
	logic [RECIP_W-1:0]  focal_y_recip_q;
	logic [CENTER_W-1:0] center_x_q;
	logic [CENTER_W-1:0] center_y_q;
	logic [DSR_W-1:0]    depth_scale_recip_q;

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_recip_q     <= FOCAL_X_RECIP_RST;
			focal_y_recip_q     <= FOCAL_Y_RECIP_RST;
			center_x_q          <= CENTER_X_RST;
			center_y_q          <= CENTER_Y_RST;
			depth_scale_recip_q <= DEPTH_SCALE_RECIP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FOCAL_X_RECIP:     focal_x_recip_q     <= pwdata[RECIP_W-1:0];
				REG_FOCAL_Y_RECIP:     focal_y_recip_q     <= pwdata[RECIP_W-1:0];
				REG_CENTER_X:          center_x_q          <= pwdata[CENTER_W-1:0];
				REG_CENTER_Y:          center_y_q          <= pwdata[CENTER_W-1:0];
				REG_DEPTH_SCALE_RECIP: depth_scale_recip_q <= pwdata[DSR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FOCAL_X_RECIP:     prdata = APB_DATA_W'(focal_x_recip_q);
			REG_FOCAL_Y_RECIP:     prdata = APB_DATA_W'(focal_y_recip_q);
			REG_CENTER_X:          prdata = APB_DATA_W'(center_x_q);
			REG_CENTER_Y:          prdata = APB_DATA_W'(center_y_q);
			REG_DEPTH_SCALE_RECIP: prdata = APB_DATA_W'(depth_scale_recip_q);
			default:               prdata = '0;
		endcase
	end

	// pipeline flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4        = !valid_s4 || !point_stall;
	assign rdy3        = !valid_s3 || rdy4;
	assign rdy2        = !valid_s2 || rdy3;
	assign rdy1        = !valid_s1 || rdy2;
	assign pixel_stall = !rdy1;
	assign point_valid = valid_s4;

	// stage 1: depth scaling and principal point offsets
	logic [PROD_W-1:0] z_prod;
	logic [POINT_W-1:0] z_c;
	logic [OFF_W-1:0]  off_x, off_y, noff_x, noff_y;

	assign z_prod = PROD_W'(depth_raw) * PROD_W'(depth_scale_recip_q);
	assign z_c    = z_prod[PROD_W-1:8];
	assign off_x  = OFF_W'({column, 4'b0000}) - OFF_W'(center_x_q);
	assign off_y  = OFF_W'({row, 4'b0000}) - OFF_W'(center_y_q);
	assign noff_x = -off_x;
	assign noff_y = -off_y;

	logic [POINT_W-1:0] z_s1, z_s2, z_s3;
	logic [MAG_W-1:0]   mag_x_s1, mag_y_s1;
	logic               neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2, neg_x_s3, neg_y_s3;
	logic [COLOR_W-1:0] red_s1, green_s1, blue_s1;
	logic [COLOR_W-1:0] red_s2, green_s2, blue_s2;
	logic [COLOR_W-1:0] red_s3, green_s3, blue_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			// zero depth is dropped here
			valid_s1 <= pixel_valid && (z_c != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && pixel_valid) begin
			z_s1     <= z_c;
			neg_x_s1 <= off_x[OFF_W-1];
			neg_y_s1 <= off_y[OFF_W-1];
			mag_x_s1 <= off_x[OFF_W-1] ? noff_x[MAG_W-1:0] : off_x[MAG_W-1:0];
			mag_y_s1 <= off_y[OFF_W-1] ? noff_y[MAG_W-1:0] : off_y[MAG_W-1:0];
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
		end
	end

	// stage 2: offset magnitude times z
	logic [M_W-1:0] m_x_s2, m_y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			m_x_s2   <= M_W'(mag_x_s1) * M_W'(z_s1);
			m_y_s2   <= M_W'(mag_y_s1) * M_W'(z_s1);
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			z_s2     <= z_s1;
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
		end
	end

	// stage 3: partial products with the focal reciprocals
	logic [63:0]      plo_x_s3, plo_y_s3;
	logic [PHI_W-1:0] phi_x_s3, phi_y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			plo_x_s3 <= 64'(m_x_s2[31:0]) * 64'(focal_x_recip_q);
			plo_y_s3 <= 64'(m_y_s2[31:0]) * 64'(focal_y_recip_q);
			phi_x_s3 <= PHI_W'(m_x_s2[M_W-1:32]) * PHI_W'(focal_x_recip_q);
			phi_y_s3 <= PHI_W'(m_y_s2[M_W-1:32]) * PHI_W'(focal_y_recip_q);
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
			z_s3     <= z_s2;
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
		end
	end

	// stage 4: combine, truncate toward zero, saturate, apply sign
	function automatic logic [POINT_W-1:0] lateral(input logic [PHI_W-1:0] phi,
			input logic [63:0] plo, input logic neg);
		logic [SUM_W-1:0] sum;
		logic [Q_W-1:0]   q;
		logic [POINT_W-1:0] r;
		sum = SUM_W'(phi) + SUM_W'(plo[63:32]);
		q   = sum[SUM_W-1:4];
		if (neg) begin
			if (q > NEG_LIM) begin
				r = 32'h8000_0000;
			end else begin
				r = -q[POINT_W-1:0];
			end
		end else if (q > POS_LIM) begin
			r = 32'h7FFF_FFFF;
		end else begin
			r = q[POINT_W-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			point_x   <= lateral(phi_x_s3, plo_x_s3, neg_x_s3);
			point_y   <= lateral(phi_y_s3, plo_y_s3, neg_y_s3);
			point_z   <= z_s3;
			red_out   <= red_s3;
			green_out <= green_s3;
			blue_out  <= blue_s3;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dpb_checker.sv
// port-level checks for the depth pixel back-projection top level
// bound to depth_pixel_backprojection_top; uses dpb_pkg widths
`default_nettype none

module dpb_checker import dpb_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               pixel_stall,
	input wire logic               point_valid,
	input wire logic               point_stall,
	input wire logic [POINT_W-1:0] point_x,
	input wire logic [POINT_W-1:0] point_y,
	input wire logic [POINT_W-1:0] point_z,
	input wire logic [COLOR_W-1:0] red_out,
	input wire logic [COLOR_W-1:0] green_out,
	input wire logic [COLOR_W-1:0] blue_out
);

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_stall |=> point_valid && $stable(point_x)
			&& $stable(point_y) && $stable(point_z) && $stable(red_out)
			&& $stable(green_out) && $stable(blue_out))
		else $error("point item changed while stalled");

	// zero depth never reaches the output
	a_z_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> point_z != '0)
		else $error("point with zero depth");

	// input only backs up when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> point_valid && point_stall)
		else $error("pixel stall without output back-pressure");

	// no point is valid at the output right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !point_valid)
		else $error("point item right after reset");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_stall (pixel_stall),
	.point_valid (point_valid),
	.point_stall (point_stall),
	.point_x     (point_x),
	.point_y     (point_y),
	.point_z     (point_z),
	.red_out     (red_out),
	.green_out   (green_out),
	.blue_out    (blue_out)
);

`default_nettype wire
